// ===== rtl/cpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants, codes and types of the circular playlist ring.
// ----------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

   localparam int CAPACITY    = 64;
   localparam int ID_W        = 32;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;
   localparam int SLOT_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   localparam int GROUP_SIZE  = 8;
   localparam int BIT_W       = $clog2(GROUP_SIZE);
   localparam int GROUP_COUNT = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GRP_W       = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int PAD_N       = GROUP_COUNT * GROUP_SIZE;

   localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
   localparam logic [OP_W-1:0] OP_ADVANCE = 3'd1;
   localparam logic [OP_W-1:0] OP_REWIND  = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      slot_type nxt;
      slot_type prv;
   } link_type;

   typedef struct packed {
      logic     scan_start;
      logic     clear_all;
      logic     set_en;
      logic     free_en;
      slot_type slot;
   } alloc_ctrl_type;

   typedef struct packed {
      logic     found;
      slot_type free_slot;
   } alloc_stat_type;

endpackage

`default_nettype wire

// ===== rtl/circular_playlist_ring_top.sv =====
// ----------------------------------------------------------------------------
// circular_playlist_ring_top
// Bounded circular doubly linked ring of 32-bit IDs with a cursor.
// ----------------------------------------------------------------------------
// One request beat gives one response beat. The block takes one request at a
// time; a finished response waits in the output register while the next
// request is taken. Clear, unused codes and requests refused on an empty or
// full ring go straight to the response; advance and rewind read the cursor
// entry first; append runs the free-slot finder over groups of 8 slots
// (1 to 8 groups), then writes the new entry and, when the ring was not empty,
// links it in behind the tail; remove walks from the head through the link
// memory, one entry per step, then unlinks. The ID and link memories
// are read once per cycle with registered read data, which sets the walk
// rate. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_playlist_ring_top (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire         [cpr_pkg::OP_W-1:0]       req_op,
   input  wire  signed [cpr_pkg::ID_W-1:0]       req_song_value,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [cpr_pkg::ID_W-1:0]       rsp_read_value,
   output logic        [cpr_pkg::STATUS_W-1:0]   rsp_status
);

   logic                             cmd_ready;
   logic                             res_valid;
   logic                             res_ready;
   logic [cpr_pkg::ID_W-1:0]         res_value;
   logic [cpr_pkg::STATUS_W-1:0]     res_status;
   cpr_pkg::alloc_ctrl_type          alloc_ctrl;
   cpr_pkg::alloc_stat_type          alloc_stat;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [cpr_pkg::ID_W-1:0]         rsp_value_ff;
   logic [cpr_pkg::STATUS_W-1:0]     rsp_status_ff;

   assign req_stall = !cmd_ready;
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   cpr_ring_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (req_valid),
      .cmd_ready  (cmd_ready),
      .cmd_op     (req_op),
      .cmd_value  ($unsigned(req_song_value)),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_value  (res_value),
      .res_status (res_status),
      .alloc_ctrl (alloc_ctrl),
      .alloc_stat (alloc_stat)
   );

   cpr_slot_alloc u_alloc (
      .clock (clock),
      .reset (reset),
      .ctrl  (alloc_ctrl),
      .stat  (alloc_stat)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_value_ff  <= res_value;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = $signed(rsp_value_ff);
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

// ===== rtl/cpr_slot_alloc.sv =====
// ----------------------------------------------------------------------------
// cpr_slot_alloc
// Slot occupancy bits and a free-slot finder that scans one group of slots
// per cycle and returns the lowest free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_slot_alloc (
   input  wire                     clock,
   input  wire                     reset,
   input  cpr_pkg::alloc_ctrl_type ctrl,
   output cpr_pkg::alloc_stat_type stat
);

   logic [cpr_pkg::CAPACITY-1:0]    used_ff, used_in;
   logic                            scan_ff, scan_in;
   logic [cpr_pkg::GRP_W-1:0]       grp_ff, grp_in;
   logic [cpr_pkg::PAD_N-1:0]       used_pad;
   logic [cpr_pkg::GROUP_SIZE-1:0]  grp_bits;
   logic                            hit;
   logic [cpr_pkg::BIT_W-1:0]       bit_ix;

   always_comb begin
      used_pad = '1;
      used_pad[cpr_pkg::CAPACITY-1:0] = used_ff;
      grp_bits = used_pad[grp_ff*cpr_pkg::GROUP_SIZE +: cpr_pkg::GROUP_SIZE];
   end

   always_comb begin
      hit    = 1'b0;
      bit_ix = '0;
      for (int b = cpr_pkg::GROUP_SIZE - 1; b >= 0; b--) begin
         if (!grp_bits[b]) begin
            hit    = 1'b1;
            bit_ix = cpr_pkg::BIT_W'(b);
         end
      end
   end

   assign stat.found     = scan_ff && hit;
   assign stat.free_slot = cpr_pkg::SLOT_W'({grp_ff, bit_ix});

   always_comb begin
      used_in = used_ff;
      scan_in = scan_ff;
      grp_in  = grp_ff;
      if (ctrl.clear_all) begin
         used_in = '0;
      end else if (ctrl.set_en) begin
         used_in[ctrl.slot] = 1'b1;
      end else if (ctrl.free_en) begin
         used_in[ctrl.slot] = 1'b0;
      end
      if (ctrl.scan_start) begin
         scan_in = 1'b1;
         grp_in  = '0;
      end else if (scan_ff) begin
         if (hit) begin
            scan_in = 1'b0;
         end else begin
            grp_in = grp_ff + cpr_pkg::GRP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         scan_ff <= 1'b0;
         grp_ff  <= '0;
      end else begin
         used_ff <= used_in;
         scan_ff <= scan_in;
         grp_ff  <= grp_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cpr_ring_engine.sv =====
// ----------------------------------------------------------------------------
// cpr_ring_engine
// Sequencer over the ID memory and the link memory: append, step, search
// and unlink, one memory access per cycle with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_ring_engine (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              cmd_valid,
   output logic                             cmd_ready,
   input  wire  [cpr_pkg::OP_W-1:0]         cmd_op,
   input  wire  [cpr_pkg::ID_W-1:0]         cmd_value,
   output logic                             res_valid,
   input  wire                              res_ready,
   output logic [cpr_pkg::ID_W-1:0]         res_value,
   output logic [cpr_pkg::STATUS_W-1:0]     res_status,
   output cpr_pkg::alloc_ctrl_type          alloc_ctrl,
   input  cpr_pkg::alloc_stat_type          alloc_stat
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_FIND    = 4'd1;
   localparam logic [3:0] S_AP_NEW  = 4'd2;
   localparam logic [3:0] S_AP_TAIL = 4'd3;
   localparam logic [3:0] S_AP_HEAD = 4'd4;
   localparam logic [3:0] S_STEP    = 4'd5;
   localparam logic [3:0] S_SEEK    = 4'd6;
   localparam logic [3:0] S_RM_PREV = 4'd7;
   localparam logic [3:0] S_RM_NEXT = 4'd8;
   localparam logic [3:0] S_RESP    = 4'd9;

   localparam logic [cpr_pkg::COUNT_W-1:0] FULL_COUNT = cpr_pkg::COUNT_W'(cpr_pkg::CAPACITY);
   localparam logic [cpr_pkg::COUNT_W-1:0] ONE_COUNT  = cpr_pkg::COUNT_W'(1);

   logic [cpr_pkg::ID_W-1:0] id_mem   [cpr_pkg::CAPACITY];
   cpr_pkg::link_type        link_mem [cpr_pkg::CAPACITY];

   logic [cpr_pkg::ID_W-1:0] id_rd_ff;
   cpr_pkg::link_type        link_rd_ff;

   logic                     mem_rd_en;
   cpr_pkg::slot_type        mem_rd_addr;
   logic                     id_wr_en;
   logic                     link_wr_next;
   logic                     link_wr_prev;
   cpr_pkg::slot_type        mem_wr_addr;
   logic [cpr_pkg::ID_W-1:0] id_wr_data;
   cpr_pkg::link_type        link_wr_data;

   logic [3:0]                        state_ff, state_in;
   logic                              dir_ff, dir_in;
   logic [cpr_pkg::ID_W-1:0]          value_ff, value_in;
   cpr_pkg::slot_type                 slot_ff, slot_in;
   cpr_pkg::slot_type                 nbr_n_ff, nbr_n_in;
   cpr_pkg::slot_type                 nbr_p_ff, nbr_p_in;
   logic [cpr_pkg::COUNT_W-1:0]       k_ff, k_in;
   cpr_pkg::slot_type                 head_ff, head_in;
   cpr_pkg::slot_type                 cursor_ff, cursor_in;
   logic [cpr_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [cpr_pkg::ID_W-1:0]          res_value_ff, res_value_in;
   logic [cpr_pkg::STATUS_W-1:0]      res_status_ff, res_status_in;

   always_ff @(posedge clock) begin
      if (id_wr_en) begin
         id_mem[mem_wr_addr] <= id_wr_data;
      end
      if (link_wr_next) begin
         link_mem[mem_wr_addr].nxt <= link_wr_data.nxt;
      end
      if (link_wr_prev) begin
         link_mem[mem_wr_addr].prv <= link_wr_data.prv;
      end
      if (mem_rd_en) begin
         id_rd_ff   <= id_mem[mem_rd_addr];
         link_rd_ff <= link_mem[mem_rd_addr];
      end
   end

   assign cmd_ready  = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_RESP);
   assign res_value  = res_value_ff;
   assign res_status = res_status_ff;

   always_comb begin
      state_in      = state_ff;
      dir_in        = dir_ff;
      value_in      = value_ff;
      slot_in       = slot_ff;
      nbr_n_in      = nbr_n_ff;
      nbr_p_in      = nbr_p_ff;
      k_in          = k_ff;
      head_in       = head_ff;
      cursor_in     = cursor_ff;
      count_in      = count_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = head_ff;
      id_wr_en      = 1'b0;
      link_wr_next  = 1'b0;
      link_wr_prev  = 1'b0;
      mem_wr_addr   = slot_ff;
      id_wr_data    = value_ff;
      link_wr_data  = '{nxt: slot_ff, prv: slot_ff};
      alloc_ctrl    = '0;
      alloc_ctrl.slot = slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               value_in      = cmd_value;
               res_value_in  = '0;
               res_status_in = cpr_pkg::ST_OK;
               state_in      = S_RESP;
               case (cmd_op) inside
                  cpr_pkg::OP_APPEND: begin
                     if (count_ff == FULL_COUNT) begin
                        res_status_in = cpr_pkg::ST_FULL;
                     end else begin
                        alloc_ctrl.scan_start = 1'b1;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = head_ff;
                        state_in    = S_FIND;
                     end
                  end
                  cpr_pkg::OP_ADVANCE, cpr_pkg::OP_REWIND: begin
                     if (count_ff == '0) begin
                        res_status_in = cpr_pkg::ST_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = cursor_ff;
                        dir_in      = (cmd_op == cpr_pkg::OP_ADVANCE);
                        state_in    = S_STEP;
                     end
                  end
                  cpr_pkg::OP_REMOVE: begin
                     if (count_ff == '0) begin
                        res_status_in = cpr_pkg::ST_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = head_ff;
                        slot_in     = head_ff;
                        k_in        = '0;
                        state_in    = S_SEEK;
                     end
                  end
                  cpr_pkg::OP_CLEAR: begin
                     alloc_ctrl.clear_all = 1'b1;
                     head_in   = '0;
                     cursor_in = '0;
                     count_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FIND: begin
            if (alloc_stat.found) begin
               slot_in  = alloc_stat.free_slot;
               state_in = S_AP_NEW;
            end
         end
         S_AP_NEW: begin
            id_wr_en          = 1'b1;
            link_wr_next      = 1'b1;
            link_wr_prev      = 1'b1;
            mem_wr_addr       = slot_ff;
            alloc_ctrl.set_en = 1'b1;
            count_in          = count_ff + ONE_COUNT;
            if (count_ff == '0) begin
               link_wr_data = '{nxt: slot_ff, prv: slot_ff};
               head_in      = slot_ff;
               cursor_in    = slot_ff;
               state_in     = S_RESP;
            end else begin
               link_wr_data = '{nxt: head_ff, prv: link_rd_ff.prv};
               nbr_p_in     = link_rd_ff.prv;
               state_in     = S_AP_TAIL;
            end
         end
         S_AP_TAIL: begin
            link_wr_next     = 1'b1;
            mem_wr_addr      = nbr_p_ff;
            link_wr_data.nxt = slot_ff;
            state_in         = S_AP_HEAD;
         end
         S_AP_HEAD: begin
            link_wr_prev     = 1'b1;
            mem_wr_addr      = head_ff;
            link_wr_data.prv = slot_ff;
            state_in         = S_RESP;
         end
         S_STEP: begin
            res_value_in = id_rd_ff;
            cursor_in    = dir_ff ? link_rd_ff.nxt : link_rd_ff.prv;
            state_in     = S_RESP;
         end
         S_SEEK: begin
            if (id_rd_ff == value_ff) begin
               if (count_ff == ONE_COUNT) begin
                  alloc_ctrl.clear_all = 1'b1;
                  head_in   = '0;
                  cursor_in = '0;
                  count_in  = '0;
                  state_in  = S_RESP;
               end else begin
                  nbr_n_in = link_rd_ff.nxt;
                  nbr_p_in = link_rd_ff.prv;
                  if (slot_ff == head_ff) begin
                     head_in = link_rd_ff.nxt;
                  end
                  if (slot_ff == cursor_ff) begin
                     cursor_in = link_rd_ff.nxt;
                  end
                  alloc_ctrl.free_en = 1'b1;
                  count_in = count_ff - ONE_COUNT;
                  state_in = S_RM_PREV;
               end
            end else if (k_ff + ONE_COUNT == count_ff) begin
               res_status_in = cpr_pkg::ST_NOT_FOUND;
               state_in      = S_RESP;
            end else begin
               k_in        = k_ff + ONE_COUNT;
               slot_in     = link_rd_ff.nxt;
               mem_rd_en   = 1'b1;
               mem_rd_addr = link_rd_ff.nxt;
            end
         end
         S_RM_PREV: begin
            link_wr_next     = 1'b1;
            mem_wr_addr      = nbr_p_ff;
            link_wr_data.nxt = nbr_n_ff;
            state_in         = S_RM_NEXT;
         end
         S_RM_NEXT: begin
            link_wr_prev     = 1'b1;
            mem_wr_addr      = nbr_n_ff;
            link_wr_data.prv = nbr_p_ff;
            state_in         = S_RESP;
         end
         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         cursor_ff <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         cursor_ff <= cursor_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff        <= dir_in;
      value_ff      <= value_in;
      slot_ff       <= slot_in;
      nbr_n_ff      <= nbr_n_in;
      nbr_p_ff      <= nbr_p_in;
      k_ff          <= k_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
   end

endmodule

`default_nettype wire

// ===== rtl/cpr_checker.sv =====
// ----------------------------------------------------------------------------
// cpr_checker
// Port-level checks of the circular playlist ring, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_valid,
   input wire                                 req_stall,
   input wire        [cpr_pkg::OP_W-1:0]      req_op,
   input wire signed [cpr_pkg::ID_W-1:0]      req_song_value,
   input wire                                 rsp_valid,
   input wire                                 rsp_stall,
   input wire signed [cpr_pkg::ID_W-1:0]      rsp_read_value,
   input wire        [cpr_pkg::STATUS_W-1:0]  rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_read_value) && $stable(rsp_status))
      else $error("stalled response beat changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cpr_pkg::ST_OK |-> rsp_read_value == '0)
      else $error("response with error status carries a nonzero value");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous request still in progress");

   a_clear_ok: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == cpr_pkg::OP_CLEAR && !rsp_valid |=>
         ##1 (rsp_valid && rsp_status == cpr_pkg::ST_OK && rsp_read_value == '0))
      else $error("clear did not answer ok within two cycles");

endmodule

bind circular_playlist_ring_top cpr_checker u_cpr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_op         (req_op),
   .req_song_value (req_song_value),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_read_value (rsp_read_value),
   .rsp_status     (rsp_status)
);

`default_nettype wire

// ===== verif/circular_playlist_ring_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_playlist_ring testbench
// Drives append, advance, rewind, remove, clear and spare op codes into the
// ring and compares every response beat with a shadow copy of the ring kept
// in a small scoreboard class. Both sides idle and stall at random, and the
// response side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module testbench;

   localparam logic [cpr_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [cpr_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam int RANDOM_ITEMS = 600;
   localparam int TAIL_CYCLES  = 100;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [cpr_pkg::ID_W-1:0]     value;
      logic [cpr_pkg::STATUS_W-1:0] status;
   } ring_reply_type;

   class playlist_shadow;
      logic [cpr_pkg::ID_W-1:0] ids [cpr_pkg::CAPACITY];
      cpr_pkg::slot_type        nxt [cpr_pkg::CAPACITY];
      cpr_pkg::slot_type        prv [cpr_pkg::CAPACITY];
      bit                       used [cpr_pkg::CAPACITY];
      cpr_pkg::slot_type        head;
      cpr_pkg::slot_type        cursor;
      int                       fill;
      ring_reply_type           awaited_replies [$];
      int                       mismatches;
      int                       checked;
      int                       peak_fill;
      int                       op_tally [8];
      int                       status_tally [4];

      function new();
         mismatches = 0;
         checked    = 0;
         peak_fill  = 0;
         foreach (op_tally[i]) op_tally[i] = 0;
         foreach (status_tally[i]) status_tally[i] = 0;
         foreach (ids[i]) begin
            ids[i] = '0;
            nxt[i] = '0;
            prv[i] = '0;
         end
         wipe();
      endfunction

      function void wipe();
         foreach (used[i]) used[i] = 1'b0;
         head   = '0;
         cursor = '0;
         fill   = 0;
      endfunction

      function int pending();
         return awaited_replies.size();
      endfunction

      function logic [cpr_pkg::ID_W-1:0] pick_stored();
         cpr_pkg::slot_type s;
         int                k;
         if (fill == 0) return $urandom;
         s = head;
         for (k = $urandom_range(0, fill - 1); k > 0; k--) s = nxt[s];
         return ids[s];
      endfunction

      function void note_request(logic [cpr_pkg::OP_W-1:0] op,
                                 logic [cpr_pkg::ID_W-1:0] v);
         ring_reply_type    r;
         cpr_pkg::slot_type s;
         cpr_pkg::slot_type n;
         cpr_pkg::slot_type p;
         int                k;
         bit                hit;
         r.value  = '0;
         r.status = cpr_pkg::ST_OK;
         s        = '0;
         case (op) inside
            cpr_pkg::OP_APPEND: begin
               if (fill >= cpr_pkg::CAPACITY) begin
                  r.status = cpr_pkg::ST_FULL;
               end else begin
                  for (k = cpr_pkg::CAPACITY - 1; k >= 0; k--)
                     if (!used[k]) s = cpr_pkg::slot_type'(k);
                  ids[s]  = v;
                  used[s] = 1'b1;
                  if (fill == 0) begin
                     nxt[s] = s;
                     prv[s] = s;
                     head   = s;
                     cursor = s;
                  end else begin
                     p         = prv[head];
                     nxt[p]    = s;
                     prv[s]    = p;
                     nxt[s]    = head;
                     prv[head] = s;
                  end
                  fill++;
               end
            end
            cpr_pkg::OP_ADVANCE, cpr_pkg::OP_REWIND: begin
               if (fill == 0) begin
                  r.status = cpr_pkg::ST_EMPTY;
               end else begin
                  r.value = ids[cursor];
                  cursor  = (op == cpr_pkg::OP_ADVANCE) ? nxt[cursor] : prv[cursor];
               end
            end
            cpr_pkg::OP_REMOVE: begin
               if (fill == 0) begin
                  r.status = cpr_pkg::ST_EMPTY;
               end else begin
                  s   = head;
                  hit = 1'b0;
                  for (k = 0; k < fill && !hit; k++) begin
                     if (ids[s] == v) hit = 1'b1;
                     else s = nxt[s];
                  end
                  if (!hit) begin
                     r.status = cpr_pkg::ST_NOT_FOUND;
                  end else if (fill == 1) begin
                     wipe();
                  end else begin
                     n      = nxt[s];
                     p      = prv[s];
                     nxt[p] = n;
                     prv[n] = p;
                     if (s == head) head = n;
                     if (s == cursor) cursor = n;
                     used[s] = 1'b0;
                     fill--;
                  end
               end
            end
            cpr_pkg::OP_CLEAR: wipe();
            default: ;
         endcase
         if (fill > peak_fill) peak_fill = fill;
         op_tally[op]++;
         status_tally[r.status]++;
         awaited_replies.push_back(r);
      endfunction

      function void check_reply(logic [cpr_pkg::ID_W-1:0] value,
                                logic [cpr_pkg::STATUS_W-1:0] status);
         ring_reply_type e;
         if (awaited_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected response beat value=%h status=%0d",
                        $realtime, value, status);
            return;
         end
         e = awaited_replies.pop_front();
         checked++;
         if (value !== e.value || status !== e.status) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: response %0d mismatch: value exp %h got %h, status exp %0d got %0d",
                        $realtime, checked, e.value, value, e.status, status);
         end
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic        [cpr_pkg::OP_W-1:0]      req_op;
   logic signed [cpr_pkg::ID_W-1:0]      req_song_value;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic signed [cpr_pkg::ID_W-1:0]      rsp_read_value;
   logic        [cpr_pkg::STATUS_W-1:0]  rsp_status;

   playlist_shadow           shadow;
   logic [cpr_pkg::ID_W-1:0] id_pool [16];
   int                       sent_items;

   circular_playlist_ring_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_song_value (req_song_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic offer(input logic [cpr_pkg::OP_W-1:0] op,
                        input logic [cpr_pkg::ID_W-1:0] v);
      int gap;
      gap = (((sent_items / 40) % 4) == 3) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_song_value <= v;
      do @(posedge clock); while (req_stall !== 1'b0);
      shadow.note_request(op, v);
      sent_items++;
   endtask

   function automatic logic [cpr_pkg::ID_W-1:0] fresh_id();
      return ($urandom_range(0, 1) == 0) ? id_pool[$urandom_range(0, 15)] : $urandom;
   endfunction

   task automatic fill_ring();
      int extra;
      extra = $urandom_range(1, 3);
      while (shadow.fill < cpr_pkg::CAPACITY) offer(cpr_pkg::OP_APPEND, fresh_id());
      repeat (extra) offer(cpr_pkg::OP_APPEND, fresh_id());
   endtask

   task automatic drain_ring();
      while (shadow.fill > 0) begin
         if ($urandom_range(0, 4) == 0) offer(cpr_pkg::OP_ADVANCE, $urandom);
         else offer(cpr_pkg::OP_REMOVE, shadow.pick_stored());
      end
   endtask

   task automatic mixed_run(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 34) offer(cpr_pkg::OP_APPEND, fresh_id());
         else if (pick < 52) offer(cpr_pkg::OP_ADVANCE, $urandom);
         else if (pick < 66) offer(cpr_pkg::OP_REWIND, $urandom);
         else if (pick < 90)
            offer(cpr_pkg::OP_REMOVE,
                  ($urandom_range(0, 3) == 0) ? fresh_id() : shadow.pick_stored());
         else if (pick < 93) offer(cpr_pkg::OP_CLEAR, $urandom);
         else offer(cpr_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                    $urandom);
      end
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         shadow.check_reply(rsp_read_value, rsp_status);
   end

   initial begin : reply_sink
      int hold;
      int taken;
      bit held_long;
      rsp_stall = 1'b0;
      taken     = 0;
      held_long = 1'b0;
      forever begin
         if (!held_long && taken >= 150) begin
            hold      = 400;
            held_long = 1'b1;
         end else if (((taken / 40) % 4) == 1) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 15);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock);
         while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0 && reset === 1'b0));
         taken++;
      end
   end

   initial begin
      int pick;
      int target;
      shadow         = new();
      sent_items     = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = cpr_pkg::OP_APPEND;
      req_song_value = '0;
      id_pool[0] = 32'h0000_0000;
      id_pool[1] = 32'hFFFF_FFFF;
      id_pool[2] = 32'h8000_0000;
      id_pool[3] = 32'h7FFF_FFFF;
      for (int i = 4; i < 16; i++) id_pool[i] = $urandom;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer(cpr_pkg::OP_ADVANCE, 32'h0000_0000);
      offer(cpr_pkg::OP_REWIND, 32'hFFFF_FFFF);
      offer(cpr_pkg::OP_REMOVE, 32'h7FFF_FFFF);
      offer(cpr_pkg::OP_CLEAR, 32'h8000_0000);
      for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
         offer(cpr_pkg::OP_W'(c), $urandom);
      offer(cpr_pkg::OP_APPEND, 32'h8000_0000);
      offer(cpr_pkg::OP_APPEND, 32'h7FFF_FFFF);
      offer(cpr_pkg::OP_APPEND, 32'h0000_0000);
      offer(cpr_pkg::OP_APPEND, 32'hFFFF_FFFF);
      offer(cpr_pkg::OP_ADVANCE, $urandom);
      offer(cpr_pkg::OP_REWIND, $urandom);
      offer(cpr_pkg::OP_REWIND, $urandom);
      offer(cpr_pkg::OP_REMOVE, 32'h1234_5678);
      offer(cpr_pkg::OP_REMOVE, 32'hFFFF_FFFF);
      offer(cpr_pkg::OP_REMOVE, 32'h8000_0000);
      offer(cpr_pkg::OP_APPEND, 32'h5555_5555);
      offer(cpr_pkg::OP_ADVANCE, $urandom);
      offer(cpr_pkg::OP_REMOVE, 32'h7FFF_FFFF);
      offer(cpr_pkg::OP_REMOVE, 32'h0000_0000);
      offer(cpr_pkg::OP_REMOVE, 32'h5555_5555);
      offer(cpr_pkg::OP_ADVANCE, $urandom);
      offer(cpr_pkg::OP_APPEND, 32'hAAAA_AAAA);
      offer(cpr_pkg::OP_CLEAR, $urandom);

      target = sent_items + RANDOM_ITEMS;
      while (sent_items < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) fill_ring();
         else if (pick < 16) drain_ring();
         else mixed_run(16);
      end
      req_valid <= 1'b0;

      while (shadow.pending() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d append, %0d advance, %0d rewind, %0d remove, %0d clear",
               sent_items, shadow.op_tally[cpr_pkg::OP_APPEND],
               shadow.op_tally[cpr_pkg::OP_ADVANCE],
               shadow.op_tally[cpr_pkg::OP_REWIND], shadow.op_tally[cpr_pkg::OP_REMOVE],
               shadow.op_tally[cpr_pkg::OP_CLEAR]);
      $display("Checked %0d responses: %0d full, %0d empty, %0d not found; peak fill %0d",
               shadow.checked, shadow.status_tally[cpr_pkg::ST_FULL],
               shadow.status_tally[cpr_pkg::ST_EMPTY],
               shadow.status_tally[cpr_pkg::ST_NOT_FOUND], shadow.peak_fill);
      if (shadow.mismatches == 0 && shadow.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/cpr_pkg.sv
rtl/cpr_slot_alloc.sv
rtl/cpr_ring_engine.sv
rtl/circular_playlist_ring_top.sv
rtl/cpr_checker.sv
verif/circular_playlist_ring_tb.sv
